FILE: hdl/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the positional list store: action and status
// codes, and the control word that is broadcast to every storage cell.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 8;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    wr_en;
        action_t action;
    } cell_ctrl_t;

endpackage

FILE: hdl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed words addressed by position, held in a row of
// cells. Read, insert before, or remove at a clamped index; each word in
// gives one word out with status and element count.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  s_      | s_action, s_index, s_value         | in,  valid/ready
//  m_      | m_data, m_status, m_count          | out, valid/ready
//
//  One word per cycle while s_ready is high: every cell shifts, loads
//  or holds in the accepting cycle, and the result lands in the output
//  register at the same edge, where m_valid is also set.
//  s_ready is high whenever the output register is empty or being taken.
//  Reset empties the list; cell contents are undefined until written.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int CAPACITY = plst_pkg::DEF_CAPACITY
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_action,
    input  logic signed [plst_pkg::INDEX_W-1:0]    s_index,
    input  logic signed [plst_pkg::WORD_W-1:0]     s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [plst_pkg::WORD_W-1:0]     m_data,
    output logic [1:0]                             m_status,
    output logic [plst_pkg::COUNT_W-1:0]           m_count
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > plst_pkg::INDEX_W - 1) ? LEN_W : plst_pkg::INDEX_W - 1;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic [LEN_W-1:0]                   len_reg;
    logic [LEN_W-1:0]                   len_next;
    logic                               out_valid_reg;
    logic signed [plst_pkg::WORD_W-1:0] out_data_reg;
    logic signed [plst_pkg::WORD_W-1:0] out_data_next;
    plst_pkg::status_t                  out_status_reg;
    plst_pkg::status_t                  status_next;
    logic [plst_pkg::COUNT_W-1:0]       out_count_reg;

    logic                               accept;
    logic                               is_empty;
    logic                               is_full;
    logic [LEN_W-1:0]                   hi;
    logic [CMP_W-1:0]                   mag_ext;
    logic [CMP_W-1:0]                   hi_ext;
    logic [LEN_W-1:0]                   pos;
    logic signed [plst_pkg::WORD_W-1:0] sel_data;
    plst_pkg::cell_ctrl_t               ctrl;

    logic signed [plst_pkg::WORD_W-1:0] cell_data [CAPACITY+1];
    logic signed [plst_pkg::WORD_W-1:0] cell_rd   [CAPACITY];

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_empty = (len_reg == '0);
    assign is_full  = (len_reg >= CAP_LEN);

    // clamp index into [0, hi]
    assign hi      = (s_action == plst_pkg::ACT_INSERT) ? len_reg : len_reg - LEN_W'(1);
    assign mag_ext = CMP_W'(s_index[plst_pkg::INDEX_W-2:0]);
    assign hi_ext  = CMP_W'(hi);

    always_comb begin
        if (s_index[plst_pkg::INDEX_W-1] || (s_index == '0)) begin
            pos = '0;
        end else if (mag_ext > hi_ext) begin
            pos = hi;
        end else begin
            pos = LEN_W'(mag_ext);
        end
    end

    always_comb begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_data = sel_data | cell_rd[i];
        end
    end

    always_comb begin
        status_next   = plst_pkg::ST_OK;
        out_data_next = '0;
        len_next      = len_reg;
        ctrl.wr_en    = 1'b0;
        ctrl.action   = plst_pkg::ACT_READ;
        case (s_action)
            plst_pkg::ACT_READ: begin
                if (is_empty) begin
                    status_next = plst_pkg::ST_EMPTY;
                end else begin
                    out_data_next = sel_data;
                end
            end
            plst_pkg::ACT_INSERT: begin
                if (is_full) begin
                    status_next = plst_pkg::ST_FULL;
                end else begin
                    ctrl.wr_en  = accept;
                    ctrl.action = plst_pkg::ACT_INSERT;
                    len_next    = len_reg + LEN_W'(1);
                end
            end
            plst_pkg::ACT_REMOVE: begin
                if (is_empty) begin
                    status_next = plst_pkg::ST_EMPTY;
                end else begin
                    out_data_next = sel_data;
                    ctrl.wr_en    = accept;
                    ctrl.action   = plst_pkg::ACT_REMOVE;
                    len_next      = len_reg - LEN_W'(1);
                end
            end
            default: begin
                status_next = plst_pkg::ST_OK;
            end
        endcase
    end

    assign cell_data[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [plst_pkg::WORD_W-1:0] left_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_rest
            assign left_w = cell_data[g-1];
        end
        plst_cell #(
            .IDX   (g),
            .POS_W (LEN_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos),
            .value      (s_value),
            .left_data  (left_w),
            .right_data (cell_data[g+1]),
            .data       (cell_data[g]),
            .rd_data    (cell_rd[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status_next;
            out_count_reg  <= plst_pkg::COUNT_W'(len_next);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign m_status = out_status_reg;
    assign m_count  = out_count_reg;

endmodule

FILE: hdl/plst_cell.sv
// ----------------------------------------------------------------------------
// plst_cell
// One storage cell of the list. Decides from the broadcast control word and
// the target position whether to hold, take its left neighbour, take its
// right neighbour or load the incoming word; offers its word when selected.
// ----------------------------------------------------------------------------
module plst_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 5
) (
    input  logic                                  aclk,
    input  plst_pkg::cell_ctrl_t                  ctrl,
    input  logic [POS_W-1:0]                      pos,
    input  logic signed [plst_pkg::WORD_W-1:0]    value,
    input  logic signed [plst_pkg::WORD_W-1:0]    left_data,
    input  logic signed [plst_pkg::WORD_W-1:0]    right_data,
    output logic signed [plst_pkg::WORD_W-1:0]    data,
    output logic signed [plst_pkg::WORD_W-1:0]    rd_data
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic signed [plst_pkg::WORD_W-1:0] data_reg;
    logic signed [plst_pkg::WORD_W-1:0] data_next;
    logic                               hit;

    assign hit = (pos == MY_POS);

    always_comb begin
        data_next = data_reg;
        if (ctrl.wr_en) begin
            case (ctrl.action)
                plst_pkg::ACT_INSERT: begin
                    if (hit) begin
                        data_next = value;
                    end else if (MY_POS > pos) begin
                        data_next = left_data;
                    end
                end
                plst_pkg::ACT_REMOVE: begin
                    if (MY_POS >= pos) begin
                        data_next = right_data;
                    end
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

FILE: hdl/plst_checker.sv
// ----------------------------------------------------------------------------
// plst_checker
// Port-level checks on the positional list store: result word stability
// under stall, and consistency of status, data and count.
// ----------------------------------------------------------------------------
module plst_checker #(
    parameter int CAPACITY = plst_pkg::DEF_CAPACITY
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [plst_pkg::WORD_W-1:0]     m_data,
    input logic [1:0]                             m_status,
    input logic [plst_pkg::COUNT_W-1:0]           m_count
);

    localparam logic [plst_pkg::COUNT_W-1:0] CAP_CNT = plst_pkg::COUNT_W'(CAPACITY);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data) && $stable(m_status)
                                && $stable(m_count))
        else $error("result word changed under stall");

    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != plst_pkg::ST_OK) |-> (m_data == '0))
        else $error("non-zero data with error status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == plst_pkg::ST_FULL) |-> (m_count == CAP_CNT))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == plst_pkg::ST_EMPTY) |-> (m_count == '0))
        else $error("empty status with non-zero count");

endmodule

bind positional_list_store plst_checker #(.CAPACITY(CAPACITY)) u_plst_checker (.*);
